// File: design/btok_pkg.sv
// Package for the byte stream tokenizer: token kinds, scan modes, character
// classes and the word structs passed between the scanner and the output queue.
// No dependencies.
package btok_pkg;

   localparam int OFFSET_BITS = 16;
   localparam int LINE_BITS   = 16;
   localparam int FIELD_BITS  = 16;
   localparam int KIND_BITS   = 6;
   localparam int QUEUE_DEPTH = 8;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);

   // token kinds
   localparam logic [KIND_BITS-1:0] K_LPAREN  = 6'd0;
   localparam logic [KIND_BITS-1:0] K_RPAREN  = 6'd1;
   localparam logic [KIND_BITS-1:0] K_LBRACE  = 6'd2;
   localparam logic [KIND_BITS-1:0] K_RBRACE  = 6'd3;
   localparam logic [KIND_BITS-1:0] K_SEMI    = 6'd4;
   localparam logic [KIND_BITS-1:0] K_COLON   = 6'd5;
   localparam logic [KIND_BITS-1:0] K_BANG    = 6'd6;
   localparam logic [KIND_BITS-1:0] K_ASSIGN  = 6'd8;
   localparam logic [KIND_BITS-1:0] K_GT      = 6'd10;
   localparam logic [KIND_BITS-1:0] K_LT      = 6'd12;
   localparam logic [KIND_BITS-1:0] K_PLUS    = 6'd14;
   localparam logic [KIND_BITS-1:0] K_MINUS   = 6'd16;
   localparam logic [KIND_BITS-1:0] K_SLASH   = 6'd18;
   localparam logic [KIND_BITS-1:0] K_STAR    = 6'd20;
   localparam logic [KIND_BITS-1:0] K_PERCENT = 6'd22;
   localparam logic [KIND_BITS-1:0] K_AND     = 6'd24;
   localparam logic [KIND_BITS-1:0] K_OR      = 6'd25;
   localparam logic [KIND_BITS-1:0] K_STRING  = 6'd26;
   localparam logic [KIND_BITS-1:0] K_NUMBER  = 6'd27;
   localparam logic [KIND_BITS-1:0] K_IDENT   = 6'd28;
   localparam logic [KIND_BITS-1:0] K_LET     = 6'd29;
   localparam logic [KIND_BITS-1:0] K_PRINT   = 6'd30;
   localparam logic [KIND_BITS-1:0] K_BOOL    = 6'd31;
   localparam logic [KIND_BITS-1:0] K_NULL    = 6'd32;
   localparam logic [KIND_BITS-1:0] K_COMMENT = 6'd33;
   localparam logic [KIND_BITS-1:0] K_EOF     = 6'd34;
   localparam logic [KIND_BITS-1:0] K_UNKNOWN = 6'd35;

   // keyword patterns, first bytes in the high positions
   localparam logic [39:0] KW_LET   = 40'h00_006C_6574;
   localparam logic [39:0] KW_PRINT = 40'h70_7269_6E74;
   localparam logic [39:0] KW_TRUE  = 40'h00_7472_7565;
   localparam logic [39:0] KW_FALSE = 40'h66_616C_7365;
   localparam logic [39:0] KW_NULL  = 40'h00_6E75_6C6C;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_QUOTE = 8'h22;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_AMP   = 8'h26;
   localparam logic [7:0] CH_BAR   = 8'h7C;
   localparam logic [7:0] CH_EQ    = 8'h3D;
   localparam logic [7:0] CH_SLASH = 8'h2F;
   localparam logic [7:0] CH_STAR  = 8'h2A;

   typedef enum logic [3:0] {
      M_IDLE, M_OP, M_NUM, M_NUM_DOT, M_IDENT, M_STR, M_LCMT, M_BCMT, M_BCMT_STAR
   } mode_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]  kind;
      logic [FIELD_BITS-1:0] start;
      logic [FIELD_BITS-1:0] len;
      logic [FIELD_BITS-1:0] line;
      logic                  last;
   } tok_type;

   // up to two words produced by one source byte
   typedef struct packed {
      logic [1:0] count;
      tok_type    a;
      tok_type    b;
   } push_type;

   function automatic logic is_digit(input logic [7:0] b);
      return (b >= 8'h30) && (b <= 8'h39);
   endfunction

   function automatic logic is_alpha(input logic [7:0] b);
      return ((b >= 8'h61) && (b <= 8'h7A)) || ((b >= 8'h41) && (b <= 8'h5A));
   endfunction

   function automatic logic is_space(input logic [7:0] b);
      return (b == 8'h20) || ((b >= 8'h09) && (b <= 8'h0D));
   endfunction

   function automatic logic [KIND_BITS-1:0] op_base(input logic [7:0] c);
      case (c)
         8'h21:   return K_BANG;
         8'h3D:   return K_ASSIGN;
         8'h3E:   return K_GT;
         8'h3C:   return K_LT;
         8'h2B:   return K_PLUS;
         8'h2D:   return K_MINUS;
         8'h2F:   return K_SLASH;
         8'h2A:   return K_STAR;
         default: return K_PERCENT;
      endcase
   endfunction

   function automatic logic [FIELD_BITS-1:0] clamp_off(input logic [OFFSET_BITS-1:0] v);
      return (64'(v) > 64'hFFFF) ? 16'hFFFF : FIELD_BITS'(v);
   endfunction

   function automatic logic [FIELD_BITS-1:0] clamp_line(input logic [LINE_BITS-1:0] v);
      return (64'(v) > 64'hFFFF) ? 16'hFFFF : FIELD_BITS'(v);
   endfunction

   function automatic logic [FIELD_BITS-1:0] sat_len(input logic [FIELD_BITS-1:0] v);
      return (v == '1) ? v : v + 1'b1;
   endfunction

endpackage

// File: design/btok_scan.sv
// Scanner: input byte register, lexer state and the single-pass token logic.
// Depends on btok_pkg.
module btok_scan
   import btok_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       in_accept,
   input  logic [7:0] in_byte,
   output logic       busy,
   output push_type   push
);

   logic                   in_v_ff, in_v_in;
   logic [7:0]             in_b_ff;
   mode_type               mode_ff, mode_in;
   logic [7:0]             pend_ff, pend_in;
   logic [OFFSET_BITS-1:0] off_ff, off_in;
   logic [LINE_BITS-1:0]   line_ff, line_in;
   logic [OFFSET_BITS-1:0] lstart_ff, lstart_in;
   logic [FIELD_BITS-1:0]  llen_ff, llen_in;
   logic [39:0]            kw_ff, kw_in;
   logic                   halt_ff, halt_in;

   assign in_v_in = in_accept;
   assign busy    = in_v_ff;

   // register the accepted byte and its valid flag
   always_ff @(posedge clock) begin
      if (reset) begin
         in_v_ff <= 1'b0;
      end else begin
         in_v_ff <= in_v_in;
      end
      if (in_accept) begin
         in_b_ff <= in_byte;
      end
   end

   // advance lexer state once per registered byte
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= M_IDLE;
         pend_ff   <= '0;
         off_ff    <= '0;
         line_ff   <= LINE_BITS'(1);
         lstart_ff <= '0;
         llen_ff   <= '0;
         kw_ff     <= '0;
         halt_ff   <= 1'b0;
      end else if (in_v_ff) begin
         mode_ff   <= mode_in;
         pend_ff   <= pend_in;
         off_ff    <= off_in;
         line_ff   <= line_in;
         lstart_ff <= lstart_in;
         llen_ff   <= llen_in;
         kw_ff     <= kw_in;
         halt_ff   <= halt_in;
      end
   end

   // decode one byte: mode logic first, then the idle dispatch if not absorbed
   always_comb begin
      logic [7:0]             b;
      logic                   absorbed;
      logic                   av, bv, iv;
      logic [KIND_BITS-1:0]   ak, bk, ik;
      logic [OFFSET_BITS-1:0] as_, bs, is_;
      logic [FIELD_BITS-1:0]  al, bl, il;
      logic [OFFSET_BITS-1:0] cur, cur_inc;
      logic [KIND_BITS-1:0]   wk;
      logic [FIELD_BITS-1:0]  tline;

      b        = in_b_ff;
      cur      = off_ff;
      cur_inc  = (off_ff == '1) ? off_ff : off_ff + 1'b1;
      absorbed = 1'b0;
      av = 1'b0; ak = K_UNKNOWN; as_ = '0; al = '0;
      bv = 1'b0; bk = K_UNKNOWN; bs  = '0; bl = '0;
      iv = 1'b0; ik = K_UNKNOWN; is_ = '0; il = '0;
      mode_in   = mode_ff;
      pend_in   = pend_ff;
      line_in   = line_ff;
      lstart_in = lstart_ff;
      llen_in   = llen_ff;
      kw_in     = kw_ff;
      halt_in   = halt_ff;

      // keyword lookup for a finished identifier
      wk = K_IDENT;
      if (llen_ff == 16'd3 && kw_ff == KW_LET) wk = K_LET;
      else if (llen_ff == 16'd5 && kw_ff == KW_PRINT) wk = K_PRINT;
      else if (llen_ff == 16'd4 && kw_ff == KW_TRUE) wk = K_BOOL;
      else if (llen_ff == 16'd5 && kw_ff == KW_FALSE) wk = K_BOOL;
      else if (llen_ff == 16'd4 && kw_ff == KW_NULL) wk = K_NULL;

      if (!halt_ff) begin
         unique case (mode_ff)
            M_OP: begin
               absorbed = 1'b1;
               mode_in  = M_IDLE;
               if (pend_ff == CH_AMP || pend_ff == CH_BAR) begin
                  av = 1'b1; as_ = lstart_ff;
                  if (b == pend_ff) begin
                     ak = (pend_ff == CH_AMP) ? K_AND : K_OR; al = 16'd2;
                  end else begin
                     ak = K_UNKNOWN; al = 16'd1; halt_in = 1'b1;
                  end
               end else if (b == CH_EQ) begin
                  av = 1'b1; ak = op_base(pend_ff) + 1'b1; as_ = lstart_ff; al = 16'd2;
               end else if (pend_ff == CH_SLASH && (b == CH_SLASH || b == CH_STAR)) begin
                  mode_in = (b == CH_SLASH) ? M_LCMT : M_BCMT;
                  llen_in = 16'd2;
               end else begin
                  av = 1'b1; ak = op_base(pend_ff); as_ = lstart_ff; al = 16'd1;
                  absorbed = 1'b0;
               end
            end
            M_NUM: begin
               if (is_digit(b)) begin
                  llen_in = sat_len(llen_ff); absorbed = 1'b1;
               end else if (b == CH_DOT) begin
                  mode_in = M_NUM_DOT; absorbed = 1'b1;
               end else begin
                  av = 1'b1; ak = K_NUMBER; as_ = lstart_ff; al = llen_ff;
                  mode_in = M_IDLE;
               end
            end
            M_NUM_DOT: begin
               absorbed = 1'b1;
               if (is_digit(b)) begin
                  llen_in = sat_len(sat_len(llen_ff)); mode_in = M_NUM;
               end else begin
                  // number first, then the stray dot
                  av = 1'b1; ak = K_NUMBER; as_ = lstart_ff; al = llen_ff;
                  bv = 1'b1; bk = K_UNKNOWN; bl = 16'd1;
                  bs = (cur == '0) ? cur : cur - 1'b1;
                  halt_in = 1'b1; mode_in = M_IDLE;
               end
            end
            M_IDENT: begin
               if (is_alpha(b) || is_digit(b)) begin
                  if (llen_ff < 16'd5) kw_in = {kw_ff[31:0], b};
                  llen_in  = sat_len(llen_ff);
                  absorbed = 1'b1;
               end else begin
                  av = 1'b1; ak = wk; as_ = lstart_ff; al = llen_ff;
                  mode_in = M_IDLE;
               end
            end
            M_STR: begin
               absorbed = 1'b1;
               if (b == CH_QUOTE) begin
                  av = 1'b1; ak = K_STRING; as_ = lstart_ff; al = llen_ff;
                  mode_in = M_IDLE;
               end else if (b == CH_NUL) begin
                  av = 1'b1; ak = K_UNKNOWN; as_ = lstart_ff; al = llen_ff;
                  halt_in = 1'b1; mode_in = M_IDLE;
               end else begin
                  llen_in = sat_len(llen_ff);
               end
            end
            M_LCMT: begin
               if (b == CH_LF || b == CH_NUL) begin
                  av = 1'b1; ak = K_COMMENT; as_ = lstart_ff; al = llen_ff;
                  mode_in = M_IDLE;
               end else begin
                  llen_in = sat_len(llen_ff); absorbed = 1'b1;
               end
            end
            M_BCMT, M_BCMT_STAR: begin
               absorbed = 1'b1;
               if (b == CH_NUL) begin
                  av = 1'b1; ak = K_UNKNOWN; as_ = lstart_ff; al = llen_ff;
                  halt_in = 1'b1; mode_in = M_IDLE;
               end else if (b == CH_SLASH && mode_ff == M_BCMT_STAR) begin
                  av = 1'b1; ak = K_COMMENT; as_ = lstart_ff; al = sat_len(llen_ff);
                  mode_in = M_IDLE;
               end else begin
                  llen_in = sat_len(llen_ff);
                  if (b == CH_LF && line_ff != '1) line_in = line_ff + 1'b1;
                  mode_in = (b == CH_STAR) ? M_BCMT_STAR : M_BCMT;
               end
            end
            default: begin
               absorbed = 1'b0;
            end
         endcase

         // idle dispatch: start a lexeme, skip white space or emit a single-byte token
         if (!absorbed) begin
            is_ = cur; il = 16'd1;
            case (b)
               CH_NUL:  begin iv = 1'b1; ik = K_EOF; il = '0; end
               8'h28:   begin iv = 1'b1; ik = K_LPAREN; end
               8'h29:   begin iv = 1'b1; ik = K_RPAREN; end
               8'h7B:   begin iv = 1'b1; ik = K_LBRACE; end
               8'h7D:   begin iv = 1'b1; ik = K_RBRACE; end
               8'h3B:   begin iv = 1'b1; ik = K_SEMI; end
               8'h3A:   begin iv = 1'b1; ik = K_COLON; end
               8'h21, 8'h3D, 8'h3E, 8'h3C, 8'h2B, 8'h2D, 8'h2F, 8'h2A, 8'h25,
               CH_AMP, CH_BAR: begin
                  pend_in = b; mode_in = M_OP; lstart_in = cur; llen_in = 16'd1;
               end
               CH_QUOTE: begin
                  mode_in = M_STR; lstart_in = cur_inc; llen_in = '0;
               end
               default: begin
                  if (is_space(b)) begin
                     if (b == CH_LF && line_ff != '1) line_in = line_ff + 1'b1;
                  end else if (is_digit(b)) begin
                     mode_in = M_NUM; lstart_in = cur; llen_in = 16'd1;
                  end else if (is_alpha(b)) begin
                     mode_in = M_IDENT; lstart_in = cur; llen_in = 16'd1;
                     kw_in = {32'd0, b};
                  end else begin
                     iv = 1'b1; ik = K_UNKNOWN; halt_in = 1'b1; mode_in = M_IDLE;
                  end
               end
            endcase
         end
      end

      // place the dispatch token in the first free slot
      if (iv) begin
         if (av) begin
            bv = 1'b1; bk = ik; bs = is_; bl = il;
         end else begin
            av = 1'b1; ak = ik; as_ = is_; al = il;
         end
      end

      // end of text resets everything, otherwise advance the offset
      off_in = cur_inc;
      if (b == CH_NUL) begin
         mode_in   = M_IDLE;
         pend_in   = '0;
         off_in    = '0;
         line_in   = LINE_BITS'(1);
         lstart_in = '0;
         llen_in   = '0;
         kw_in     = '0;
         halt_in   = 1'b0;
      end

      tline = clamp_line(line_ff);
      push.a = '{kind: ak, start: clamp_off(as_), len: al, line: tline, last: !bv};
      push.b = '{kind: bk, start: clamp_off(bs), len: bl, line: tline, last: 1'b1};
      push.count = in_v_ff ? ((av && bv) ? 2'd2 : (av ? 2'd1 : 2'd0)) : 2'd0;
   end

   // a halted scanner never holds a lexeme open
   a_halt_idle: assert property (@(posedge clock) disable iff (reset)
      halt_ff |-> mode_ff == M_IDLE)
      else $error("halted with open lexeme");

   // line count never drops below one
   a_line_nonzero: assert property (@(posedge clock) disable iff (reset)
      line_ff != '0)
      else $error("line count is zero");

   // end of text always leaves a clean state
   a_eot_reset: assert property (@(posedge clock) disable iff (reset)
      (in_v_ff && in_b_ff == CH_NUL) |=> (off_ff == '0 && !halt_ff))
      else $error("end of text did not reset state");

endmodule

// File: design/btok_outq.sv
// Output queue: takes up to two token words per cycle, hands out one per cycle when popped.
// Depends on btok_pkg.
module btok_outq
   import btok_pkg::*;
(
   input  logic                 clock,
   input  logic                 reset,
   input  push_type             push,
   input  logic                 pop,
   output logic                 not_empty,
   output logic [QPTR_BITS:0]   fill,
   output tok_type              head
);

   tok_type              mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [QPTR_BITS:0]   cnt_ff, cnt_in;
   logic                 do_pop;

   assign not_empty = (cnt_ff != '0);
   assign fill      = cnt_ff;
   assign head      = mem_ff[rd_ff];
   assign do_pop    = pop && not_empty;

   // advance pointers and count
   always_comb begin
      wr_in  = wr_ff + QPTR_BITS'(push.count);
      rd_in  = rd_ff + QPTR_BITS'(do_pop);
      cnt_in = cnt_ff + (QPTR_BITS+1)'(push.count) - (QPTR_BITS+1)'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   // store the words
   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         mem_ff[wr_ff] <= push.a;
      end
      if (push.count == 2'd2) begin
         mem_ff[wr_ff + 1'b1] <= push.b;
      end
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= (QPTR_BITS+1)'(QUEUE_DEPTH))
      else $error("output queue overflow");

   a_push_fits: assert property (@(posedge clock) disable iff (reset)
      (QPTR_BITS+2)'(cnt_ff) + (QPTR_BITS+2)'(push.count)
         <= (QPTR_BITS+2)'(QUEUE_DEPTH))
      else $error("push into full queue");

   a_pop_moves: assert property (@(posedge clock) disable iff (reset)
      (do_pop && push.count == 2'd0) |=> cnt_ff == $past(cnt_ff) - 1'b1)
      else $error("pop did not drain queue");

endmodule

// File: design/byte_stream_tokenizer.sv
// Top level of the byte stream tokenizer: scanner plus output queue.
// Depends on btok_pkg, btok_scan and btok_outq.
//
// Usage:
//   req_ channel carries one source byte per word; byte 0 ends a text and
//   yields an eof token (unless the text was halted by an error).
//   rsp_ channel carries one token per word: kind, start, length, line and
//   last_of_run, set on the final token that a given byte produced.
//   Each byte gives zero, one or two tokens.
// Timing:
//   A byte accepted at an edge is decoded in the following cycle; its tokens
//   enter the output queue at the end of that cycle and the first is offered from then on.
//   Without stalls, one byte is accepted and one token leaves per cycle;
//   the eight-entry output queue absorbs two-token bytes.
// Stall:
//   req_stall rises when the queue, plus the byte in decode, might lack room
//   for two more tokens. rsp_stall only holds the queue head.
// Reset:
//   Synchronous; clears the queue and the lexer state (offset 0, line 1).
module byte_stream_tokenizer
   import btok_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [7:0]            req_source_byte,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [KIND_BITS-1:0]  rsp_token_kind,
   output logic [FIELD_BITS-1:0] rsp_token_start,
   output logic [FIELD_BITS-1:0] rsp_token_length,
   output logic [FIELD_BITS-1:0] rsp_token_line,
   output logic                  rsp_last_of_run
);

   push_type           push;
   tok_type            head;
   logic               busy;
   logic [QPTR_BITS:0] fill;
   logic [QPTR_BITS+1:0] reserved;

   // reserve room for the byte in decode and the incoming one
   assign reserved  = (QPTR_BITS+2)'(fill) + (busy ? (QPTR_BITS+2)'(2) : '0);
   assign req_stall = reserved > (QPTR_BITS+2)'(QUEUE_DEPTH - 2);

   btok_scan u_scan (
      .clock     (clock),
      .reset     (reset),
      .in_accept (req_valid && !req_stall),
      .in_byte   (req_source_byte),
      .busy      (busy),
      .push      (push)
   );

   btok_outq u_outq (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (!rsp_stall),
      .not_empty (rsp_valid),
      .fill      (fill),
      .head      (head)
   );

   assign rsp_token_kind   = head.kind;
   assign rsp_token_start  = head.start;
   assign rsp_token_length = head.len;
   assign rsp_token_line   = head.line;
   assign rsp_last_of_run  = head.last;

endmodule

// File: verif/tokenizer_checker.sv
// Token checker for the byte stream tokenizer: watches both channels, predicts
// the tokens of every accepted byte and compares each delivered token in order.
// Depends on btok_pkg.
`timescale 1ns / 100ps

module tokenizer_checker
   import btok_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   input  logic                  req_stall,
   input  logic [7:0]            req_source_byte,
   input  logic                  rsp_valid,
   input  logic                  rsp_stall,
   input  logic [KIND_BITS-1:0]  rsp_token_kind,
   input  logic [FIELD_BITS-1:0] rsp_token_start,
   input  logic [FIELD_BITS-1:0] rsp_token_length,
   input  logic [FIELD_BITS-1:0] rsp_token_line,
   input  logic                  rsp_last_of_run,
   output int                    fail_count,
   output int                    tokens_pending
);

   // lexer state of the predictor
   mode_type        lex_mode;
   logic [7:0]      op_first;
   logic [15:0]     src_offset;
   logic [15:0]     line_no;
   logic [15:0]     lex_start;
   logic [15:0]     lex_len;
   logic [39:0]     word_prefix;
   logic            halted;

   tok_type         token_queue[$];
   tok_type         new_tok[2];
   int              new_count;

   function automatic logic [15:0] bump(input logic [15:0] v);
      return (v == 16'hFFFF) ? v : v + 16'd1;
   endfunction

   function automatic logic [KIND_BITS-1:0] single_op(input logic [7:0] c);
      case (c)
         "!":     return K_BANG;
         "=":     return K_ASSIGN;
         ">":     return K_GT;
         "<":     return K_LT;
         "+":     return K_PLUS;
         "-":     return K_MINUS;
         "/":     return K_SLASH;
         "*":     return K_STAR;
         default: return K_PERCENT;
      endcase
   endfunction

   function automatic logic digit_ch(input logic [7:0] b);
      return b >= "0" && b <= "9";
   endfunction

   function automatic logic alpha_ch(input logic [7:0] b);
      return (b >= "a" && b <= "z") || (b >= "A" && b <= "Z");
   endfunction

   task automatic clear_lexer();
      lex_mode    = M_IDLE;
      op_first    = 8'h00;
      src_offset  = 16'd0;
      line_no     = 16'd1;
      lex_start   = 16'd0;
      lex_len     = 16'd0;
      word_prefix = 40'd0;
      halted      = 1'b0;
   endtask

   task automatic add_token(input logic [KIND_BITS-1:0] kind, input logic [15:0] start,
                            input logic [15:0] len);
      new_tok[new_count] = '{kind: kind, start: start, len: len, line: line_no, last: 1'b0};
      new_count++;
   endtask

   task automatic halt_text(input logic [15:0] start, input logic [15:0] len);
      add_token(K_UNKNOWN, start, len);
      halted   = 1'b1;
      lex_mode = M_IDLE;
   endtask

   // advance the predictor by one source byte
   task automatic predict_tokens(input logic [7:0] b);
      logic            taken;
      logic [15:0]     cur;
      logic [KIND_BITS-1:0] wkind;
      taken     = 1'b0;
      cur       = src_offset;
      new_count = 0;
      if (!halted) begin
         case (lex_mode)
            M_OP: begin
               taken = 1'b1;
               if (op_first == CH_AMP || op_first == CH_BAR) begin
                  if (b == op_first) begin
                     add_token(op_first == CH_AMP ? K_AND : K_OR, lex_start, 16'd2);
                     lex_mode = M_IDLE;
                  end else begin
                     halt_text(lex_start, 16'd1);
                  end
               end else if (b == CH_EQ) begin
                  add_token(single_op(op_first) + 6'd1, lex_start, 16'd2);
                  lex_mode = M_IDLE;
               end else if (op_first == CH_SLASH && (b == CH_SLASH || b == CH_STAR)) begin
                  lex_mode = (b == CH_SLASH) ? M_LCMT : M_BCMT;
                  lex_len  = 16'd2;
               end else begin
                  add_token(single_op(op_first), lex_start, 16'd1);
                  lex_mode = M_IDLE;
                  taken    = 1'b0;
               end
            end
            M_NUM: begin
               taken = 1'b1;
               if (digit_ch(b)) lex_len = bump(lex_len);
               else if (b == CH_DOT) lex_mode = M_NUM_DOT;
               else begin
                  add_token(K_NUMBER, lex_start, lex_len);
                  lex_mode = M_IDLE;
                  taken    = 1'b0;
               end
            end
            M_NUM_DOT: begin
               taken = 1'b1;
               if (digit_ch(b)) begin
                  lex_len  = bump(bump(lex_len));
                  lex_mode = M_NUM;
               end else begin
                  add_token(K_NUMBER, lex_start, lex_len);
                  halt_text(cur == 16'd0 ? 16'd0 : cur - 16'd1, 16'd1);
               end
            end
            M_IDENT: begin
               if (alpha_ch(b) || digit_ch(b)) begin
                  taken = 1'b1;
                  if (lex_len < 16'd5) word_prefix = {word_prefix[31:0], b};
                  lex_len = bump(lex_len);
               end else begin
                  wkind = K_IDENT;
                  if (lex_len == 16'd3 && word_prefix == KW_LET) wkind = K_LET;
                  else if (lex_len == 16'd5 && word_prefix == KW_PRINT) wkind = K_PRINT;
                  else if (lex_len == 16'd4 && word_prefix == KW_TRUE) wkind = K_BOOL;
                  else if (lex_len == 16'd5 && word_prefix == KW_FALSE) wkind = K_BOOL;
                  else if (lex_len == 16'd4 && word_prefix == KW_NULL) wkind = K_NULL;
                  add_token(wkind, lex_start, lex_len);
                  lex_mode = M_IDLE;
               end
            end
            M_STR: begin
               taken = 1'b1;
               if (b == CH_QUOTE) begin
                  add_token(K_STRING, lex_start, lex_len);
                  lex_mode = M_IDLE;
               end else if (b == CH_NUL) begin
                  halt_text(lex_start, lex_len);
               end else begin
                  lex_len = bump(lex_len);
               end
            end
            M_LCMT: begin
               if (b == CH_LF || b == CH_NUL) begin
                  add_token(K_COMMENT, lex_start, lex_len);
                  lex_mode = M_IDLE;
               end else begin
                  taken   = 1'b1;
                  lex_len = bump(lex_len);
               end
            end
            M_BCMT, M_BCMT_STAR: begin
               taken = 1'b1;
               if (b == CH_NUL) begin
                  halt_text(lex_start, lex_len);
               end else begin
                  lex_len = bump(lex_len);
                  if (b == CH_SLASH && lex_mode == M_BCMT_STAR) begin
                     add_token(K_COMMENT, lex_start, lex_len);
                     lex_mode = M_IDLE;
                  end else begin
                     if (b == CH_LF) line_no = bump(line_no);
                     lex_mode = (b == CH_STAR) ? M_BCMT_STAR : M_BCMT;
                  end
               end
            end
            default: taken = 1'b0;
         endcase

         // start a new lexeme or emit a single-byte token from idle
         if (!taken && !halted) begin
            case (b)
               CH_NUL: add_token(K_EOF, cur, 16'd0);
               "(":    add_token(K_LPAREN, cur, 16'd1);
               ")":    add_token(K_RPAREN, cur, 16'd1);
               "{":    add_token(K_LBRACE, cur, 16'd1);
               "}":    add_token(K_RBRACE, cur, 16'd1);
               ";":    add_token(K_SEMI, cur, 16'd1);
               ":":    add_token(K_COLON, cur, 16'd1);
               "!", "=", ">", "<", "+", "-", "/", "*", "%", "&", "|": begin
                  op_first  = b;
                  lex_mode  = M_OP;
                  lex_start = cur;
                  lex_len   = 16'd1;
               end
               CH_QUOTE: begin
                  lex_mode  = M_STR;
                  lex_start = bump(cur);
                  lex_len   = 16'd0;
               end
               default: begin
                  if (b == " " || (b >= 8'h09 && b <= 8'h0D)) begin
                     if (b == CH_LF) line_no = bump(line_no);
                  end else if (digit_ch(b)) begin
                     lex_mode  = M_NUM;
                     lex_start = cur;
                     lex_len   = 16'd1;
                  end else if (alpha_ch(b)) begin
                     lex_mode    = M_IDENT;
                     lex_start   = cur;
                     lex_len     = 16'd1;
                     word_prefix = {32'd0, b};
                  end else begin
                     halt_text(cur, 16'd1);
                  end
               end
            endcase
         end
      end

      if (b == CH_NUL) clear_lexer();
      else src_offset = bump(src_offset);

      if (new_count > 0) new_tok[new_count-1].last = 1'b1;
      for (int i = 0; i < new_count; i++) token_queue.push_back(new_tok[i]);
   endtask

   task automatic report(input string field, input int got, input int want);
      $display("ERROR %0t: token %s got %0d expected %0d", $realtime, field, got, want);
      fail_count++;
   endtask

   // predict on accepted bytes, compare on accepted tokens
   always @(posedge clock) begin
      tok_type want;
      if (reset) begin
         clear_lexer();
         token_queue.delete();
         fail_count = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (token_queue.size() == 0) begin
               report("without expectation, kind", rsp_token_kind, -1);
            end else begin
               want = token_queue.pop_front();
               if (rsp_token_kind != want.kind) report("kind", rsp_token_kind, want.kind);
               if (rsp_token_start != want.start) report("start", rsp_token_start, want.start);
               if (rsp_token_length != want.len) report("length", rsp_token_length, want.len);
               if (rsp_token_line != want.line) report("line", rsp_token_line, want.line);
               if (rsp_last_of_run != want.last) report("last", rsp_last_of_run, want.last);
            end
         end
         if (req_valid && !req_stall) predict_tokens(req_source_byte);
      end
      tokens_pending = token_queue.size();
   end

endmodule

// File: verif/tb_byte_stream_tokenizer.sv
// Testbench top for the byte stream tokenizer: clock, reset, source text
// stimulus, receiver stall pattern, watchdog and verdict.
// Depends on btok_pkg, byte_stream_tokenizer and tokenizer_checker.
`timescale 1ns / 100ps

module tb_byte_stream_tokenizer;
   import btok_pkg::*;

   localparam int IDLE_LIMIT    = 3000;
   localparam int LONG_HOLD     = 250;
   localparam int RANDOM_BYTES  = 1750;
   localparam int COMMENT_LINES = 20;
   localparam int DRAIN_CYCLES  = 20;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic [7:0]            req_source_byte = 8'h00;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [KIND_BITS-1:0]  rsp_token_kind;
   logic [FIELD_BITS-1:0] rsp_token_start;
   logic [FIELD_BITS-1:0] rsp_token_length;
   logic [FIELD_BITS-1:0] rsp_token_line;
   logic                  rsp_last_of_run;
   int                    fail_count;
   int                    tokens_pending;

   int                    burst_left = 0;
   int                    hold_requests = 0;
   int                    idle_cycles = 0;
   int                    random_sent = 0;
   logic [7:0]            text_q[$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   byte_stream_tokenizer dut (
      .clock, .reset, .req_valid, .req_stall, .req_source_byte,
      .rsp_valid, .rsp_stall, .rsp_token_kind, .rsp_token_start,
      .rsp_token_length, .rsp_token_line, .rsp_last_of_run
   );

   tokenizer_checker u_checker (
      .clock, .reset, .req_valid, .req_stall, .req_source_byte,
      .rsp_valid, .rsp_stall, .rsp_token_kind, .rsp_token_start,
      .rsp_token_length, .rsp_token_line, .rsp_last_of_run,
      .fail_count, .tokens_pending
   );

   // receiver: long hold on request, else alternate free and choppy stretches
   always @(posedge clock) begin
      int phase;
      int hold_left;
      int holds_taken;
      if (reset) begin
         rsp_stall <= 1'b0;
         phase = 0;
         hold_left = 0;
         holds_taken = 0;
      end else begin
         if (holds_taken != hold_requests) begin
            holds_taken = hold_requests;
            hold_left = LONG_HOLD;
         end
         if (hold_left > 0) begin
            rsp_stall <= 1'b1;
            hold_left--;
         end else begin
            if (phase == 0) phase = $urandom_range(1, 80);
            phase--;
            if ((phase / 20) % 2 == 0) rsp_stall <= 1'b0;
            else rsp_stall <= ($urandom_range(0, 2) == 0);
         end
      end
   end

   // watchdog on cycles without any accepted word
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // offer one byte, in bursts with random gaps
   task automatic send_byte(input logic [7:0] b);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid       <= 1'b1;
      req_source_byte <= b;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   task automatic send_text(input string s, input logic terminate);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      if (terminate) send_byte(CH_NUL);
   endtask

   function automatic logic [7:0] pick_char(input string s);
      return s[$urandom_range(0, s.len() - 1)];
   endfunction

   // append every character of a string to text_q
   task automatic push_str(input string s);
      for (int i = 0; i < s.len(); i++) text_q.push_back(s[i]);
   endtask

   // build one random text, mostly well formed, into text_q
   task automatic build_text();
      int pieces;
      int n;
      string letters;
      letters = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ";
      pieces = $urandom_range(1, 12);
      for (int p = 0; p < pieces; p++) begin
         case ($urandom_range(0, 15))
            0: begin
               case ($urandom_range(0, 4))
                  0: push_str("let");
                  1: push_str("print");
                  2: push_str("true");
                  3: push_str("false");
                  default: push_str("null");
               endcase
            end
            1, 2: begin
               text_q.push_back(pick_char(letters));
               n = $urandom_range(0, 7);
               repeat (n) text_q.push_back($urandom_range(0, 1) ? pick_char(letters)
                                                                 : pick_char("0123456789"));
            end
            3, 4: begin
               repeat ($urandom_range(1, 4)) text_q.push_back(pick_char("0123456789"));
               if ($urandom_range(0, 2) == 0) begin
                  text_q.push_back(CH_DOT);
                  if ($urandom_range(0, 4) != 0) text_q.push_back(pick_char("0123456789"));
               end
            end
            5: begin
               text_q.push_back(CH_QUOTE);
               repeat ($urandom_range(0, 6)) text_q.push_back($urandom_range(0, 3) == 0
                                                     ? CH_LF : 8'($urandom_range(32, 126)));
               if ($urandom_range(0, 7) != 0) text_q.push_back(CH_QUOTE);
            end
            6: begin
               push_str("//");
               repeat ($urandom_range(0, 6)) text_q.push_back(8'($urandom_range(32, 126)));
               if ($urandom_range(0, 3) != 0) text_q.push_back(CH_LF);
            end
            7: begin
               push_str("/*");
               repeat ($urandom_range(0, 6)) text_q.push_back(pick_char("*/ a\n"));
               if ($urandom_range(0, 7) != 0) push_str("*/");
            end
            8, 9: begin
               text_q.push_back(pick_char("!=<>+-/*%"));
               if ($urandom_range(0, 1)) text_q.push_back(CH_EQ);
            end
            10: begin
               n = $urandom_range(0, 5);
               text_q.push_back(n < 2 ? CH_AMP : CH_BAR);
               if (n != 0 && n != 2) text_q.push_back(n < 2 ? CH_AMP : CH_BAR);
            end
            11: text_q.push_back(pick_char("(){};:"));
            12: text_q.push_back(pick_char("\n\t\r\v\f"));
            13: text_q.push_back(8'($urandom_range(1, 255)));
            default: text_q.push_back(" ");
         endcase
         if ($urandom_range(0, 1)) text_q.push_back(" ");
      end
      if ($urandom_range(0, 5) == 0) begin
         repeat ($urandom_range(1, 5)) text_q.push_back(8'($urandom_range(1, 255)));
      end
      text_q.push_back(CH_NUL);
   endtask

   task automatic send_random_texts(input int count);
      int sent;
      sent = 0;
      while (sent < count) begin
         text_q.delete();
         build_text();
         foreach (text_q[i]) send_byte(text_q[i]);
         sent += text_q.size();
      end
      random_sent += sent;
   endtask

   initial begin
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // keywords, every operator and punctuation, halting cases
      send_text("let print true false null x1 abcdef9", 1'b1);
      send_text("(){};:! != = == > >= < <= + += - -= / /= * *= % %= && ||", 1'b1);
      send_text("\"s\nx\" 12.5 7.x 1", 1'b1);
      send_text("&a", 1'b1);
      send_text("|", 1'b1);
      send_text("// c\n/* a\n**/ */", 1'b1);
      send_text("a//x", 1'b1);
      send_text("\"open", 1'b1);
      send_text("/* open", 1'b1);
      send_byte(8'hFF);
      send_byte(CH_NUL);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(CH_NUL);

      // count newlines inside one block comment
      send_text("/*", 1'b0);
      repeat (COMMENT_LINES) send_byte(CH_LF);
      send_text("*/ x 5", 1'b1);

      // fill the block behind a long receiver hold
      hold_requests++;
      send_random_texts(120);

      // let everything drain before going on
      req_valid <= 1'b0;
      @(posedge clock);
      wait (tokens_pending == 0);
      @(posedge clock);

      while (random_sent < RANDOM_BYTES) send_random_texts(100);

      req_valid <= 1'b0;
      @(posedge clock);
      wait (tokens_pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (fail_count == 0 && tokens_pending == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
